[sv/mf5_pkg.sv]
// Shared constants and types of the 5x5 median filter.
package mf5_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int WIN        = 5;
   localparam int LINES      = WIN - 1;
   localparam int TAPS       = WIN * WIN;
   localparam int MID        = TAPS / 2;
   localparam int HALF       = WIN / 2;

   localparam int PIX_W  = 8;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int CSR_W  = 11;
   localparam int RANK_W = $clog2(TAPS + 1);
   localparam int RSP_W  = ((PIX_W + ROW_W + COL_W + 7) / 8) * 8;
   localparam int RSP_PAD = RSP_W - PIX_W - ROW_W - COL_W;

   typedef logic [PIX_W-1:0]  pixel_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [CSR_W-1:0]  csr_type;
   typedef logic [RANK_W-1:0] rank_type;

   typedef pixel_type [LINES-1:0] lines_type;
   typedef pixel_type [WIN-1:0]   column_type;
   typedef pixel_type [TAPS-1:0]  taps_type;
   typedef rank_type  [TAPS-1:0]  ranks_type;

endpackage

[sv/median_filter_5x5.sv]
// Streaming 5x5 median filter: line store, window, rank and select stages.
//
// Pixels arrive in raster order, one word per clock, with tuser set on the first pixel of a
// frame. For each input pixel at row >= 4 and column >= 4 the block returns one word: the
// median of the 5x5 neighbourhood centred two rows up and two columns left, with that centre's
// row and column; other pixels return nothing, so the two-pixel border is left to the host.
// Throughput is one pixel per clock; a result passes the line store read, window shift, rank
// count and median select stages; backpressure on the result side stalls the whole pipeline.
// The line store is a single-port-write, single-port-read memory of MAX_WIDTH words of four
// pixels; it needs no clearing pass, since every entry is written before an interior result
// reads it. The row counter stops at 1023. csr_wdata sets the row width (clamped to 5..1024);
// the user must write it only while the block is idle, which the block does not enforce.
module median_filter_5x5 (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [10:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [7:0] median_value, [17:8] out_row, [27:18] out_col
);

   logic                adv;
   logic                req_fire;

   mf5_pkg::csr_type    width_ff;
   mf5_pkg::csr_type    width_eff;

   mf5_pkg::col_type    col_ff, col_in, col_cur;
   mf5_pkg::row_type    row_ff, row_in, row_cur;
   logic                emit_a;

   logic                p1_valid_ff;
   mf5_pkg::pixel_type  p1_pixel_ff;
   mf5_pkg::col_type    p1_addr_ff;
   logic                p1_emit_ff;
   mf5_pkg::row_type    p1_row_ff;
   mf5_pkg::col_type    p1_col_ff;
   logic                p1_byp_ff;
   mf5_pkg::lines_type  p1_byp_data_ff;
   mf5_pkg::lines_type  rd_data_ff;

   mf5_pkg::lines_type  line_mem [mf5_pkg::MAX_WIDTH];

   mf5_pkg::lines_type  lines_b;
   mf5_pkg::column_type col_b;
   logic                wr_en;
   mf5_pkg::col_type    wr_addr;
   mf5_pkg::lines_type  wr_data;

   mf5_pkg::taps_type   win_ff, win_in;

   logic                p2_valid_ff;
   mf5_pkg::row_type    p2_row_ff;
   mf5_pkg::col_type    p2_col_ff;

   logic [mf5_pkg::TAPS-1:0] lt_bits, le_bits;
   mf5_pkg::ranks_type  lt_c, le_c;
   logic                p3_valid_ff;
   mf5_pkg::taps_type   p3_win_ff;
   mf5_pkg::ranks_type  p3_lt_ff, p3_le_ff;
   mf5_pkg::row_type    p3_row_ff;
   mf5_pkg::col_type    p3_col_ff;

   mf5_pkg::pixel_type  med_d;
   logic                found_d;

   logic                rsp_tvalid_ff;
   mf5_pkg::pixel_type  rsp_med_ff;
   mf5_pkg::row_type    rsp_row_ff;
   mf5_pkg::col_type    rsp_col_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign req_fire   = req_tvalid && adv;

   // Width register
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= mf5_pkg::CSR_W'(mf5_pkg::MAX_WIDTH);
      end else if (csr_wen) begin
         width_ff <= csr_wdata;
      end
   end

   always_comb begin
      width_eff = width_ff;
      if (width_ff < mf5_pkg::CSR_W'(mf5_pkg::WIN)) begin
         width_eff = mf5_pkg::CSR_W'(mf5_pkg::WIN);
      end else if (width_ff > mf5_pkg::CSR_W'(mf5_pkg::MAX_WIDTH)) begin
         width_eff = mf5_pkg::CSR_W'(mf5_pkg::MAX_WIDTH);
      end
   end

   // Position counters
   always_comb begin
      col_cur = req_tuser ? '0 : col_ff;
      row_cur = req_tuser ? '0 : row_ff;
      emit_a  = (row_cur >= mf5_pkg::ROW_W'(mf5_pkg::LINES)) &&
                (col_cur >= mf5_pkg::COL_W'(mf5_pkg::LINES));
      if ((mf5_pkg::CSR_W'(col_cur) + mf5_pkg::CSR_W'(1)) >= width_eff) begin
         col_in = '0;
         row_in = (row_cur < mf5_pkg::ROW_W'(mf5_pkg::MAX_HEIGHT - 1)) ?
                  row_cur + mf5_pkg::ROW_W'(1) : row_cur;
      end else begin
         col_in = col_cur + mf5_pkg::COL_W'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 1: take the word, read the line store
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_pixel_ff    <= req_tdata;
         p1_addr_ff     <= col_cur;
         p1_emit_ff     <= emit_a;
         p1_row_ff      <= row_cur - mf5_pkg::ROW_W'(mf5_pkg::HALF);
         p1_col_ff      <= col_cur - mf5_pkg::COL_W'(mf5_pkg::HALF);
         p1_byp_ff      <= wr_en && (wr_addr == col_cur);
         p1_byp_data_ff <= wr_data;
         rd_data_ff     <= line_mem[col_cur];
      end
   end

   // Stage 2: write back the shifted column, shift the window
   always_comb begin
      lines_b = p1_byp_ff ? p1_byp_data_ff : rd_data_ff;
      for (int k = 0; k < mf5_pkg::LINES; k++) begin
         col_b[k] = lines_b[k];
      end
      col_b[mf5_pkg::LINES] = p1_pixel_ff;
      for (int k = 0; k < mf5_pkg::LINES; k++) begin
         wr_data[k] = col_b[k+1];
      end
      wr_en   = adv && p1_valid_ff;
      wr_addr = p1_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      for (int r = 0; r < mf5_pkg::WIN; r++) begin
         for (int j = 0; j < mf5_pkg::WIN - 1; j++) begin
            win_in[r*mf5_pkg::WIN + j] = win_ff[r*mf5_pkg::WIN + j + 1];
         end
         win_in[r*mf5_pkg::WIN + mf5_pkg::WIN - 1] = col_b[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff      <= '0;
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         if (p1_valid_ff) begin
            win_ff <= win_in;
         end
         p2_valid_ff <= p1_valid_ff && p1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_row_ff <= p1_row_ff;
         p2_col_ff <= p1_col_ff;
      end
   end

   // Stage 3: rank every tap against the others
   always_comb begin
      lt_bits = '0;
      le_bits = '0;
      for (int i = 0; i < mf5_pkg::TAPS; i++) begin
         for (int j = 0; j < mf5_pkg::TAPS; j++) begin
            lt_bits[j] = (win_ff[j] <  win_ff[i]);
            le_bits[j] = (win_ff[j] <= win_ff[i]);
         end
         lt_c[i] = mf5_pkg::RANK_W'($countones(lt_bits));
         le_c[i] = mf5_pkg::RANK_W'($countones(le_bits));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_win_ff <= win_ff;
         p3_lt_ff  <= lt_c;
         p3_le_ff  <= le_c;
         p3_row_ff <= p2_row_ff;
         p3_col_ff <= p2_col_ff;
      end
   end

   // Stage 4: pick the tap whose rank spans the middle
   always_comb begin
      med_d   = '0;
      found_d = 1'b0;
      for (int i = 0; i < mf5_pkg::TAPS; i++) begin
         if ((p3_lt_ff[i] <= mf5_pkg::RANK_W'(mf5_pkg::MID)) &&
             (p3_le_ff[i] >  mf5_pkg::RANK_W'(mf5_pkg::MID))) begin
            med_d   = med_d | p3_win_ff[i];
            found_d = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_med_ff <= med_d;
         rsp_row_ff <= p3_row_ff;
         rsp_col_ff <= p3_col_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{mf5_pkg::RSP_PAD{1'b0}}, rsp_col_ff, rsp_row_ff, rsp_med_ff};

`ifndef NO_ASSERTIONS
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> p1_valid_ff)
      else $error("accepted word did not enter stage 1");

   a_median_found: assert property (@(posedge clock) disable iff (reset)
      p3_valid_ff |-> found_d)
      else $error("no tap holds the middle rank");

   a_centre_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_row_ff >= mf5_pkg::ROW_W'(mf5_pkg::HALF)) &&
                     (rsp_col_ff >= mf5_pkg::COL_W'(mf5_pkg::HALF)) &&
                     (rsp_col_ff <= mf5_pkg::COL_W'(mf5_pkg::MAX_WIDTH - 1 - mf5_pkg::HALF)))
      else $error("result centre lies in the border");
`endif

endmodule

[tb/sv/median_filter_5x5_tb.sv]
// Testbench for median_filter_5x5: random and directed pixel streams checked by a scoreboard.
`timescale 1ns / 1ps

typedef struct packed {
   logic [mf5_pkg::RSP_PAD-1:0] pad;
   mf5_pkg::col_type            col;
   mf5_pkg::row_type            row;
   mf5_pkg::pixel_type          median;
} median_word_type;

class median_scoreboard;
   mf5_pkg::csr_type   width_raw;
   mf5_pkg::pixel_type history [mf5_pkg::LINES][mf5_pkg::MAX_WIDTH];
   mf5_pkg::pixel_type window [mf5_pkg::WIN][mf5_pkg::WIN];
   int unsigned        col_cnt;
   int unsigned        row_cnt;
   median_word_type    awaited [$];
   int                 errors;

   function new();
      width_raw = mf5_pkg::csr_type'(mf5_pkg::MAX_WIDTH);
      foreach (history[k, c]) history[k][c] = '0;
      foreach (window[r, c]) window[r][c] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors  = 0;
   endfunction

   function void set_width(mf5_pkg::csr_type value);
      width_raw = value;
   endfunction

   function int pending();
      return awaited.size();
   endfunction

   function mf5_pkg::pixel_type median_of_window();
      mf5_pkg::pixel_type flat [mf5_pkg::TAPS];
      mf5_pkg::pixel_type pick;
      int                 below;
      int                 upto;
      pick = '0;
      foreach (window[r, c]) flat[r * mf5_pkg::WIN + c] = window[r][c];
      for (int i = 0; i < mf5_pkg::TAPS; i++) begin
         below = 0;
         upto  = 0;
         for (int j = 0; j < mf5_pkg::TAPS; j++) begin
            if (flat[j] < flat[i]) below++;
            if (flat[j] <= flat[i]) upto++;
         end
         if (below <= mf5_pkg::MID && upto > mf5_pkg::MID) pick = flat[i];
      end
      return pick;
   endfunction

   function void note_pixel(mf5_pkg::pixel_type px, logic frame_start);
      int unsigned        w;
      int unsigned        c;
      mf5_pkg::pixel_type fresh [mf5_pkg::WIN];
      median_word_type    m;
      w = width_raw;
      if (w < mf5_pkg::WIN) w = mf5_pkg::WIN;
      if (w > mf5_pkg::MAX_WIDTH) w = mf5_pkg::MAX_WIDTH;
      if (frame_start) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      c = (col_cnt >= mf5_pkg::MAX_WIDTH) ? mf5_pkg::MAX_WIDTH - 1 : col_cnt;
      for (int k = 0; k < mf5_pkg::LINES; k++) fresh[k] = history[k][c];
      fresh[mf5_pkg::LINES] = px;
      for (int k = 0; k < mf5_pkg::LINES; k++) history[k][c] = fresh[k + 1];
      for (int r = 0; r < mf5_pkg::WIN; r++) begin
         for (int j = 0; j + 1 < mf5_pkg::WIN; j++) window[r][j] = window[r][j + 1];
         window[r][mf5_pkg::WIN-1] = fresh[r];
      end
      if (row_cnt >= mf5_pkg::LINES && col_cnt >= mf5_pkg::LINES) begin
         m.pad    = '0;
         m.median = median_of_window();
         m.row    = mf5_pkg::row_type'(row_cnt - mf5_pkg::HALF);
         m.col    = mf5_pkg::col_type'(col_cnt - mf5_pkg::HALF);
         awaited.push_back(m);
      end
      if (col_cnt + 1 >= w) begin
         col_cnt = 0;
         if (row_cnt < mf5_pkg::MAX_HEIGHT - 1) row_cnt++;
      end else begin
         col_cnt++;
      end
   endfunction

   task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   task check_word(logic [mf5_pkg::RSP_W-1:0] word);
      median_word_type got;
      median_word_type want;
      got = word;
      if (awaited.size() == 0) begin
         report_mismatch($sformatf("unexpected word %h", word));
         return;
      end
      want = awaited.pop_front();
      if (got.median !== want.median)
         report_mismatch($sformatf("median %h, want %h at (%0d,%0d)",
                                   got.median, want.median, want.row, want.col));
      if (got.row !== want.row)
         report_mismatch($sformatf("row %0d, want %0d", got.row, want.row));
      if (got.col !== want.col)
         report_mismatch($sformatf("col %0d, want %0d", got.col, want.col));
      if (got.pad !== want.pad)
         report_mismatch($sformatf("pad bits %h not zero", got.pad));
   endtask
endclass

module median_filter_5x5_tb;

   localparam int CYCLE_LIMIT    = 3_000_000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int RANDOM_PIXELS  = 1400;

   typedef enum {SCENE_RANDOM, SCENE_CHECKER, SCENE_BRIGHT, SCENE_RAMP} scene_type;

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      csr_wen    = 1'b0;
   logic [10:0]               csr_wdata  = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [mf5_pkg::RSP_W-1:0] rsp_tdata;

   median_scoreboard sb = new();
   scene_type        scene   = SCENE_RANDOM;
   bit               steady  = 1'b0;
   bit               squeeze = 1'b0;
   int unsigned      cycle_count = 0;

   median_filter_5x5 dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready === 1'b1) sb.note_pixel(req_tdata, req_tuser);
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) sb.check_word(rsp_tdata);
   end

   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic mf5_pkg::pixel_type pick_pixel(int n, int unsigned w);
      int roll;
      roll = $urandom_range(0, 99);
      case (scene)
         SCENE_CHECKER: return (((n / w) + (n % w)) % 2) ? 8'hFF : 8'h00;
         SCENE_BRIGHT:  return 8'hFF;
         SCENE_RAMP:    return mf5_pkg::pixel_type'(n * 37);
         default: begin
            if (roll < 5) return 8'h00;
            if (roll < 10) return 8'hFF;
            return mf5_pkg::pixel_type'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // hold off the result side at random, with one long hold on request
   initial begin : result_side
      int hold;
      @(posedge clock);
      forever begin
         if (squeeze) begin
            squeeze = 1'b0;
            rsp_tready <= 1'b0;
            hold = 0;
            while (hold < SQUEEZE_CYCLES) begin
               @(posedge clock);
               hold++;
            end
         end
         hold = pick_gap();
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            while (hold > 0 && !squeeze) begin
               @(posedge clock);
               hold--;
            end
         end
         if (!squeeze) begin
            rsp_tready <= 1'b1;
            hold = $urandom_range(1, 12);
            while (hold > 0 && !squeeze) begin
               @(posedge clock);
               hold--;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("median_filter_5x5_tb: FAIL");
      $finish;
   end

   task send_pixel(input mf5_pkg::pixel_type px, input logic frame_start);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= frame_start;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic stream_frame(input int unsigned w, input int unsigned rows,
                               input int unsigned tail, input bit fresh,
                               input int squeeze_at);
      int total;
      total = rows * w + tail;
      for (int n = 0; n < total; n++) begin
         if (n == squeeze_at) squeeze = 1'b1;
         send_pixel(pick_pixel(n, w), fresh && n == 0);
      end
   endtask

   task settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_width(input mf5_pkg::csr_type value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.set_width(value);
   endtask

   initial begin : stimulus
      int          random_pixels;
      int unsigned raw;
      int unsigned w;
      int unsigned rows;
      int unsigned widest;
      int unsigned frames;
      int          roll;
      bit          fresh;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // width below the minimum, no frame start on the first word after reset
      write_width(11'd0);
      scene = SCENE_CHECKER;
      stream_frame(mf5_pkg::WIN, 6, 0, 1'b0, -1);
      settle();
      write_width(11'd4);
      scene = SCENE_BRIGHT;
      stream_frame(mf5_pkg::WIN, 5, 3, 1'b1, -1);
      scene = SCENE_RAMP;
      stream_frame(mf5_pkg::WIN, 5, 2, 1'b1, -1);
      settle();

      // hold the result side for a long stretch while the row is still being offered
      write_width(11'd12);
      scene = SCENE_RANDOM;
      stream_frame(12, 5, 10, 1'b1, 4 * 12 + 5);
      settle();

      // shrink the row while the column is already past the new width
      write_width(11'd6);
      stream_frame(6, 3, 2, 1'b0, -1);
      settle();

      widest = 12;
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         steady = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 10) raw = $urandom_range(0, mf5_pkg::WIN - 1);
         else if (roll < 85) raw = $urandom_range(mf5_pkg::WIN, 24);
         else raw = $urandom_range(25, 64);
         w = (raw < mf5_pkg::WIN) ? mf5_pkg::WIN : raw;
         write_width(mf5_pkg::csr_type'(raw));
         frames = $urandom_range(1, 2);
         for (int f = 0; f < frames; f++) begin
            fresh = (f > 0) || (w > widest) || ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0) rows = $urandom_range(0, 3);
            else if (w > 48) rows = $urandom_range(4, 5);
            else rows = $urandom_range(4, 9);
            raw = $urandom_range(0, w - 1);
            stream_frame(w, rows, raw, fresh, -1);
            random_pixels += rows * w + raw;
            if (rows > 0 && w > widest) widest = w;
            if (random_pixels >= RANDOM_PIXELS) break;
         end
         settle();
      end
      steady = 1'b0;

      // width above the maximum is clamped
      write_width(11'h7FF);
      stream_frame(mf5_pkg::MAX_WIDTH, 0, 8, 1'b1, -1);
      settle();

      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("median_filter_5x5_tb: PASS");
      end else begin
         $display("median_filter_5x5_tb: FAIL");
      end
      $finish;
   end

endmodule

[files.f]
sv/mf5_pkg.sv
sv/median_filter_5x5.sv
tb/sv/median_filter_5x5_tb.sv
